FILE: design/gmm_diagonal_m_step_top_macros.svh
// assertion macros for the gmm m-step block
`ifndef GMM_DIAGONAL_M_STEP_TOP_MACROS_SVH
`define GMM_DIAGONAL_M_STEP_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define GMM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gmm check failed");

// next-cycle implication
`define GMM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gmm check failed");

`endif

FILE: design/gmm_pkg.sv
// shared types and constants for the gmm m-step block
package gmm_pkg;

	localparam int MAX_PIXELS_DEF   = 4096;
	localparam int NUM_CLUSTERS_DEF = 4;

	localparam int NUM_CHAN = 3;
	localparam int NUM_PROB = 4;
	localparam int CHAN_W   = 8;
	localparam int PROB_W   = 16;
	localparam int MEAN_W   = 16;
	localparam int VAR_W    = 24;
	localparam int ID_W     = 2;
	localparam int PIX_W    = NUM_CHAN * CHAN_W;
	localparam int ROW_W    = PIX_W + NUM_PROB * PROB_W;
	localparam int DEV_W    = 64;
	localparam int MUL_A_W  = 32;
	localparam int MUL_W    = MUL_A_W + PROB_W;
	localparam int DIV_NW   = 64;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic REG_TINY_OFFSET = 1'b0;
	localparam logic [PROB_W-1:0] TINY_OFFSET_RST = 16'd1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_P1_RD,
		ST_P1_MUL,
		ST_P1_ACC,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_P2_RD,
		ST_P2_SQ,
		ST_P2_MP,
		ST_P2_ACC,
		ST_VAR_GO,
		ST_VAR_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: design/gmm_ram.sv
// generic single-write, single-read ram with registered read
module gmm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/gmm_div.sv
// iterative restoring divider, one quotient bit per cycle
module gmm_div import gmm_pkg::*; #(
	parameter int NW = DIV_NW,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [NW-1:0] quot,
	output div_stat_t     stat
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic [DW:0]   rem_sub;
	logic          ge;

	assign rem_sh  = {rem_q, n_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[NW-2:0], ge};
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	assign quot      = n_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

FILE: design/gmm_diagonal_m_step_top.sv
// gmm m-step top: pixel store, sequencer, shared multiplier and divider
// pixels load at one per cycle while busy is low; the last_pixel word raises busy
// per cluster: pass one over the stored pixels, three mean divisions, pass two, three variance divisions
// (an empty cluster emits after pass one); pass two reads, squares, weights and accumulates per channel
// one result per cluster on a one-cycle done strobe, results cannot be stalled
// async reset clears control and counts; the pixel store needs no clearing
`include "gmm_diagonal_m_step_top_macros.svh"

module gmm_diagonal_m_step_top import gmm_pkg::*; #(
	parameter int MAX_PIXELS   = MAX_PIXELS_DEF,
	parameter int NUM_CLUSTERS = NUM_CLUSTERS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CHAN_W-1:0] chan_0,
	input  logic [CHAN_W-1:0] chan_1,
	input  logic [CHAN_W-1:0] chan_2,
	input  logic [PROB_W-1:0] prob_0,
	input  logic [PROB_W-1:0] prob_1,
	input  logic [PROB_W-1:0] prob_2,
	input  logic [PROB_W-1:0] prob_3,
	input  logic              last_pixel,
	output logic              done,
	output logic [ID_W-1:0]   cluster_id,
	output logic [MEAN_W-1:0] mean_0,
	output logic [MEAN_W-1:0] mean_1,
	output logic [MEAN_W-1:0] mean_2,
	output logic [VAR_W-1:0]  var_0,
	output logic [VAR_W-1:0]  var_1,
	output logic [VAR_W-1:0]  var_2,
	output logic              empty_cluster,
	output logic              last_cluster,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
	localparam int ADDR_W = $clog2(MAX_PIXELS);
	localparam int WS_W   = PROB_W + CNT_W;
	localparam int CS_W   = PROB_W + CHAN_W + CNT_W;
	localparam int DEN_W  = WS_W + 8;
	localparam int NCL    = NUM_CLUSTERS < NUM_PROB ? NUM_CLUSTERS : NUM_PROB;
	localparam logic [ID_W-1:0]  LAST_K  = ID_W'(NCL - 1);
	localparam logic [1:0]       LAST_C  = 2'(NUM_CHAN - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  idx_q;
	logic [ID_W-1:0]   k_q;
	logic [1:0]        c_q;
	logic [WS_W-1:0]   w_q;
	logic [CS_W-1:0]   s_q    [NUM_CHAN];
	logic [DEV_W-1:0]  dev_q  [NUM_CHAN];
	logic [MEAN_W-1:0] mean_q [NUM_CHAN];
	logic [VAR_W-1:0]  var_q  [NUM_CHAN];
	logic [MUL_W-1:0]  mul_q;
	logic [PROB_W-1:0] tiny_q;

	logic              done_q;
	logic [ID_W-1:0]   id_q;
	logic [MEAN_W-1:0] mean_o_q [NUM_CHAN];
	logic [VAR_W-1:0]  var_o_q  [NUM_CHAN];
	logic              empty_q;
	logic              lastc_q;

	logic              accept;
	logic              ram_we;
	logic [ROW_W-1:0]  ram_wdata;
	logic [ROW_W-1:0]  rd_data;
	logic [CHAN_W-1:0] chan_rd [NUM_CHAN];
	logic [PROB_W-1:0] prob_rd [NUM_PROB];
	logic [CHAN_W-1:0] chan_sel;
	logic [PROB_W-1:0] prob_sel;
	logic [MEAN_W-1:0] chan_ext;
	logic [MEAN_W-1:0] mean_sel;
	logic [MEAN_W-1:0] abs_dev;
	logic              pix_last;
	logic              w_zero;
	logic [MUL_A_W-1:0] mul_a;
	logic [PROB_W-1:0]  mul_b;
	logic [DEV_W:0]    dev_add;
	logic [DEV_W-1:0]  dev_next;
	logic [DEV_W:0]    var_add;
	logic [DEV_W-1:0]  var_num;
	logic [DIV_NW-1:0] mean_num;
	logic              div_start;
	logic              div_mean;
	logic [DIV_NW-1:0] div_num;
	logic [DEN_W-1:0]  div_den;
	logic [DIV_NW-1:0] div_quot;
	div_stat_t         div_stat;
	logic              q_big;
	logic [VAR_W:0]    var_sum;
	logic [VAR_W-1:0]  var_val;
	logic              cfg_wr;

	assign accept    = start && !busy;
	assign busy      = state_q != ST_LOAD;
	assign ram_we    = accept && (cnt_q != CNT_MAX);
	assign ram_wdata = {prob_3, prob_2, prob_1, prob_0, chan_2, chan_1, chan_0};

	gmm_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_PIXELS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[ADDR_W-1:0]),
		.wdata(ram_wdata),
		.raddr(idx_q[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			chan_rd[c] = rd_data[c*CHAN_W +: CHAN_W];
		end
		for (int k = 0; k < NUM_PROB; k++) begin
			prob_rd[k] = rd_data[PIX_W + k*PROB_W +: PROB_W];
		end
	end

	assign chan_sel = chan_rd[c_q];
	assign prob_sel = prob_rd[k_q];
	assign chan_ext = {chan_sel, 8'b0};
	assign mean_sel = mean_q[c_q];
	assign abs_dev  = (chan_ext >= mean_sel) ? chan_ext - mean_sel : mean_sel - chan_ext;
	assign pix_last = (idx_q + CNT_W'(1)) == cnt_q;
	assign w_zero   = w_q == '0;

	// saturating deviation accumulate
	assign dev_add  = {1'b0, dev_q[c_q]} + (DEV_W+1)'(mul_q);
	assign dev_next = dev_add[DEV_W] ? '1 : dev_add[DEV_W-1:0];

	// rounding terms for the two divisions
	assign var_add  = {1'b0, dev_q[c_q]} + (DEV_W+1)'({w_q, 7'b0});
	assign var_num  = var_add[DEV_W] ? '1 : var_add[DEV_W-1:0];
	assign mean_num = DIV_NW'({s_q[c_q], 8'b0}) + DIV_NW'(w_q >> 1);
	assign div_num  = div_mean ? mean_num : var_num;
	assign div_den  = div_mean ? DEN_W'(w_q) : {w_q, 8'b0};

	gmm_div #(
		.NW(DIV_NW),
		.DW(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.quot  (div_quot),
		.stat  (div_stat)
	);

	assign q_big   = |div_quot[DIV_NW-1:VAR_W];
	assign var_sum = {1'b0, div_quot[VAR_W-1:0]} + (VAR_W+1)'(tiny_q);
	assign var_val = (q_big || var_sum[VAR_W]) ? '1 : var_sum[VAR_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (accept && last_pixel) state_d = ST_P1_RD;
			end
			ST_P1_RD:  state_d = ST_P1_MUL;
			ST_P1_MUL: state_d = ST_P1_ACC;
			ST_P1_ACC: begin
				if (c_q != LAST_C) state_d = ST_P1_MUL;
				else if (!pix_last) state_d = ST_P1_RD;
				else if (w_zero) state_d = ST_EMIT;
				else state_d = ST_MEAN_GO;
			end
			ST_MEAN_GO: state_d = ST_MEAN_WAIT;
			ST_MEAN_WAIT: begin
				if (div_stat.done) begin
					state_d = (c_q == LAST_C) ? ST_P2_RD : ST_MEAN_GO;
				end
			end
			ST_P2_RD: state_d = ST_P2_SQ;
			ST_P2_SQ: state_d = ST_P2_MP;
			ST_P2_MP: state_d = ST_P2_ACC;
			ST_P2_ACC: begin
				if (c_q != LAST_C) state_d = ST_P2_SQ;
				else if (!pix_last) state_d = ST_P2_RD;
				else state_d = ST_VAR_GO;
			end
			ST_VAR_GO: state_d = ST_VAR_WAIT;
			ST_VAR_WAIT: begin
				if (div_stat.done) begin
					state_d = (c_q == LAST_C) ? ST_EMIT : ST_VAR_GO;
				end
			end
			ST_EMIT: state_d = (k_q == LAST_K) ? ST_LOAD : ST_P1_RD;
			default: state_d = ST_LOAD;
		endcase
	end

	// unit controls
	always_comb begin
		div_start = 1'b0;
		div_mean  = 1'b0;
		mul_a     = MUL_A_W'(chan_sel);
		mul_b     = prob_sel;
		case (state_q)
			ST_MEAN_GO: begin
				div_start = 1'b1;
				div_mean  = 1'b1;
			end
			ST_MEAN_WAIT: div_mean = 1'b1;
			ST_VAR_GO:    div_start = 1'b1;
			ST_P2_SQ: begin
				mul_a = MUL_A_W'(abs_dev);
				mul_b = abs_dev;
			end
			ST_P2_MP: mul_a = mul_q[MUL_A_W-1:0];
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == ST_EMIT;
			if (ram_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == ST_EMIT && k_q == LAST_K) begin
				cnt_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				idx_q <= '0;
				c_q   <= '0;
				k_q   <= '0;
				w_q   <= '0;
				for (int c = 0; c < NUM_CHAN; c++) s_q[c] <= '0;
			end
			ST_P1_MUL: begin
				if (c_q == 2'd0) w_q <= w_q + WS_W'(prob_sel);
			end
			ST_P1_ACC: begin
				s_q[c_q] <= s_q[c_q] + CS_W'(mul_q[PIX_W-1:0]);
				if (c_q == LAST_C) begin
					c_q <= '0;
					if (!pix_last) idx_q <= idx_q + CNT_W'(1);
				end else begin
					c_q <= c_q + 2'd1;
				end
			end
			ST_MEAN_WAIT: begin
				if (div_stat.done) begin
					mean_q[c_q] <= div_quot[MEAN_W-1:0];
					if (c_q == LAST_C) begin
						c_q   <= '0;
						idx_q <= '0;
						for (int c = 0; c < NUM_CHAN; c++) dev_q[c] <= '0;
					end else begin
						c_q <= c_q + 2'd1;
					end
				end
			end
			ST_P2_ACC: begin
				dev_q[c_q] <= dev_next;
				if (c_q == LAST_C) begin
					c_q <= '0;
					if (!pix_last) idx_q <= idx_q + CNT_W'(1);
				end else begin
					c_q <= c_q + 2'd1;
				end
			end
			ST_VAR_WAIT: begin
				if (div_stat.done) begin
					var_q[c_q] <= var_val;
					c_q <= (c_q == LAST_C) ? 2'd0 : c_q + 2'd1;
				end
			end
			ST_EMIT: begin
				id_q    <= k_q;
				empty_q <= w_zero;
				lastc_q <= k_q == LAST_K;
				for (int c = 0; c < NUM_CHAN; c++) begin
					mean_o_q[c] <= w_zero ? '0 : mean_q[c];
					var_o_q[c]  <= w_zero ? '0 : var_q[c];
					s_q[c]      <= '0;
				end
				k_q   <= k_q + ID_W'(1);
				idx_q <= '0;
				c_q   <= '0;
				w_q   <= '0;
			end
			default: begin
				c_q <= c_q;
			end
		endcase
	end

	// configuration port
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TINY_OFFSET) ? APB_DW'(tiny_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tiny_q <= TINY_OFFSET_RST;
		end else if (cfg_wr && paddr[2] == REG_TINY_OFFSET) begin
			tiny_q <= pwdata[PROB_W-1:0];
		end
	end

	assign done          = done_q;
	assign cluster_id    = id_q;
	assign mean_0        = mean_o_q[0];
	assign mean_1        = mean_o_q[1];
	assign mean_2        = mean_o_q[2];
	assign var_0         = var_o_q[0];
	assign var_1         = var_o_q[1];
	assign var_2         = var_o_q[2];
	assign empty_cluster = empty_q;
	assign last_cluster  = lastc_q;

	`GMM_ASSERT_NXT(a_last_raises_busy, start && !busy && last_pixel, busy)
	`GMM_ASSERT_IMP(a_run_ends_cleared, done && last_cluster, !busy && cnt_q == '0)
	`GMM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_MAX)
	`GMM_ASSERT_IMP(a_empty_zero, done && empty_cluster, mean_0 == '0 && var_0 == '0)
	`GMM_ASSERT_IMP(a_div_idle_start, div_start, !div_stat.busy)

endmodule

FILE: test/tb_gmm_diagonal_m_step_top.sv
// testbench for the gmm m-step block: directed and random images checked against a software predictor
`timescale 1ns / 100ps

module tb_gmm_diagonal_m_step_top;
	import gmm_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [MEAN_W-1:0] m0;
		logic [MEAN_W-1:0] m1;
		logic [MEAN_W-1:0] m2;
		logic [VAR_W-1:0]  v0;
		logic [VAR_W-1:0]  v1;
		logic [VAR_W-1:0]  v2;
		logic              empty;
		logic              last;
	} cluster_res_t;

	class gmm_scoreboard;
		bit [CHAN_W-1:0] pix_mem[MAX_PIXELS_DEF][NUM_CHAN];
		bit [PROB_W-1:0] prob_mem[MAX_PIXELS_DEF][NUM_PROB];
		int unsigned count;
		longint unsigned wsum[NUM_PROB];
		longint unsigned csum[NUM_PROB][NUM_CHAN];
		bit [PROB_W-1:0] offset;
		cluster_res_t pending[$];
		int errors;

		function new();
			offset = TINY_OFFSET_RST;
			count = 0;
			errors = 0;
			foreach (wsum[k]) wsum[k] = 0;
			foreach (csum[k, c]) csum[k][c] = 0;
		endfunction

		static function longint unsigned sat_add(longint unsigned a, longint unsigned b);
			longint unsigned s;
			s = a + b;
			return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
		endfunction

		// accepted pixel word; a last_pixel word queues one result per cluster
		function void note_pixel(bit [CHAN_W-1:0] ch[NUM_CHAN], bit [PROB_W-1:0] pr[NUM_PROB],
				bit last);
			longint unsigned w, m, dev, den, v, ad;
			longint signed d;
			bit [MEAN_W-1:0] mean[NUM_CHAN];
			bit [VAR_W-1:0] vr[NUM_CHAN];
			cluster_res_t r;
			if (count < MAX_PIXELS_DEF) begin
				for (int c = 0; c < NUM_CHAN; c++) pix_mem[count][c] = ch[c];
				for (int k = 0; k < NUM_PROB; k++) begin
					prob_mem[count][k] = pr[k];
					wsum[k] += pr[k];
					for (int c = 0; c < NUM_CHAN; c++) csum[k][c] += longint'(pr[k]) * ch[c];
				end
				count++;
			end
			if (!last) return;
			for (int k = 0; k < NUM_PROB; k++) begin
				w = wsum[k];
				for (int c = 0; c < NUM_CHAN; c++) begin
					mean[c] = '0;
					vr[c] = '0;
				end
				if (w != 0) begin
					for (int c = 0; c < NUM_CHAN; c++) begin
						m = ((csum[k][c] << 8) + (w >> 1)) / w;
						mean[c] = (m > 64'hFFFF) ? 16'hFFFF : m[15:0];
					end
					for (int c = 0; c < NUM_CHAN; c++) begin
						dev = 0;
						for (int i = 0; i < count; i++) begin
							d = longint'(pix_mem[i][c]) * 256 - longint'(mean[c]);
							ad = (d < 0) ? -d : d;
							dev = sat_add(dev, ad * ad * prob_mem[i][k]);
						end
						den = w << 8;
						v = sat_add(dev, den >> 1) / den + offset;
						vr[c] = (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
					end
				end
				r.id = ID_W'(k);
				r.m0 = mean[0];
				r.m1 = mean[1];
				r.m2 = mean[2];
				r.v0 = vr[0];
				r.v1 = vr[1];
				r.v2 = vr[2];
				r.empty = (w == 0);
				r.last = (k == NUM_PROB - 1);
				pending.push_back(r);
			end
			count = 0;
			foreach (wsum[k]) wsum[k] = 0;
			foreach (csum[k, c]) csum[k][c] = 0;
		endfunction

		function void check_result(cluster_res_t got);
			cluster_res_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected cluster word %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch cl%0d exp m=%h/%h/%h v=%h/%h/%h e=%b l=%b",
						" got cl%0d m=%h/%h/%h v=%h/%h/%h e=%b l=%b"},
						want.id, want.m0, want.m1, want.m2, want.v0, want.v1, want.v2,
						want.empty, want.last, got.id, got.m0, got.m1, got.m2,
						got.v0, got.v1, got.v2, got.empty, got.last);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0, start = 0, last_pixel = 0;
	logic [CHAN_W-1:0] chan_0 = 0, chan_1 = 0, chan_2 = 0;
	logic [PROB_W-1:0] prob_0 = 0, prob_1 = 0, prob_2 = 0, prob_3 = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [APB_AW-1:0] paddr = 0;
	logic [APB_DW-1:0] pwdata = 0;
	logic busy, done, empty_cluster, last_cluster, pready;
	logic [ID_W-1:0] cluster_id;
	logic [MEAN_W-1:0] mean_0, mean_1, mean_2;
	logic [VAR_W-1:0] var_0, var_1, var_2;
	logic [APB_DW-1:0] prdata;

	gmm_scoreboard sb = new();

	gmm_diagonal_m_step_top uut (.*);

	always #1 clk = ~clk;

	initial begin
		#5_000_000;
		$display("tb_gmm_diagonal_m_step_top: FAIL");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check_result({cluster_id, mean_0, mean_1, mean_2, var_0, var_1, var_2,
				empty_cluster, last_cluster});

	task automatic write_offset(bit [PROB_W-1:0] val);
		@(negedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= APB_AW'({REG_TINY_OFFSET, 2'b00});
		pwdata <= APB_DW'(val);
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		sb.offset = val;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
	endtask

	// holds start high until the word is taken; a gap is optional afterwards
	task automatic send_pixel(bit [CHAN_W-1:0] ch[NUM_CHAN], bit [PROB_W-1:0] pr[NUM_PROB],
			bit last, bit gaps);
		int g;
		start <= 1;
		{chan_0, chan_1, chan_2} <= {ch[0], ch[1], ch[2]};
		{prob_0, prob_1, prob_2, prob_3} <= {pr[0], pr[1], pr[2], pr[3]};
		last_pixel <= last;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_pixel(ch, pr, last);
		@(negedge clk);
		g = 0;
		if (gaps && $urandom_range(0, 2) == 0)
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (g > 0) begin
			start <= 0;
			repeat (g) @(negedge clk);
		end
	endtask

	// drop start at once so the last word is not taken again when busy falls
	task automatic wait_idle();
		start <= 0;
		wait (sb.pending.size() == 0);
		@(negedge clk);
		while (busy) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// one image of n pixels; zmask forces whole clusters to zero weight
	task automatic send_image(int n, bit gaps);
		bit [CHAN_W-1:0] ch[NUM_CHAN];
		bit [PROB_W-1:0] pr[NUM_PROB];
		bit [NUM_PROB-1:0] zmask;
		zmask = ($urandom_range(0, 3) == 0) ? NUM_PROB'($urandom) : '0;
		for (int i = 0; i < n; i++) begin
			foreach (ch[c]) ch[c] = CHAN_W'($urandom);
			foreach (pr[k]) begin
				case ($urandom_range(0, 7))
					0: pr[k] = '0;
					1: pr[k] = 16'hFFFF;
					default: pr[k] = PROB_W'($urandom);
				endcase
				if (zmask[k]) pr[k] = '0;
			end
			send_pixel(ch, pr, i == n - 1, gaps);
		end
	endtask

	initial begin
		bit [CHAN_W-1:0] ch[NUM_CHAN];
		bit [PROB_W-1:0] pr[NUM_PROB];
		int sent;
		repeat (5) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: extremes, an empty cluster, a single-pixel image
		ch = '{8'hFF, 8'h00, 8'hFF};
		pr = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001};
		send_pixel(ch, pr, 1, 0);
		wait_idle();
		write_offset(16'h0000);
		ch = '{8'h00, 8'hFF, 8'h80};
		pr = '{16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF};
		send_pixel(ch, pr, 0, 0);
		ch = '{8'hFF, 8'h00, 8'h7F};
		pr = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000};
		send_pixel(ch, pr, 0, 1);
		ch = '{8'h55, 8'hAA, 8'h01};
		pr = '{16'h0001, 16'h0000, 16'h5555, 16'hFFFF};
		send_pixel(ch, pr, 1, 0);
		wait_idle();
		write_offset(16'hFFFF);
		send_image(6, 1);
		wait_idle();

		sent = 10;
		while (sent < 310) begin
			int n;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
			send_image(n, $urandom_range(0, 3) != 0);
			sent += n;
			if ($urandom_range(0, 4) == 0) begin
				wait_idle();
				case ($urandom_range(0, 3))
					0: write_offset(16'h0000);
					1: write_offset(16'hFFFF);
					default: write_offset(PROB_W'($urandom));
				endcase
			end
		end
		wait_idle();
		repeat (50) @(negedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_gmm_diagonal_m_step_top: PASS");
		else
			$display("tb_gmm_diagonal_m_step_top: FAIL");
		$finish;
	end

endmodule
